// File: hw/rtl/dfcr_pkg.sv
// Package with constants and types for the duplicated frame command receiver.
package dfcr_pkg;
   localparam int FrameBytes = 32;
   localparam int QueueDepth = 128;
   localparam int PulseBits  = 24;
   localparam int FillBits   = $clog2(FrameBytes + 1);
   localparam int FrameAw    = $clog2(FrameBytes);
   localparam int QueueAw    = $clog2(QueueDepth);
   localparam int QFillBits  = $clog2(QueueDepth + 1);
   localparam int MagBits    = 45;

   localparam logic [7:0] CharHash  = 8'h23;
   localparam logic [7:0] CharSemi  = 8'h3B;
   localparam logic [7:0] CharBang  = 8'h21;
   localparam logic [7:0] CharX     = 8'h58;
   localparam logic [7:0] CharR     = 8'h52;
   localparam logic [7:0] CharI     = 8'h49;
   localparam logic [7:0] CharD     = 8'h44;
   localparam logic [7:0] CharS     = 8'h53;
   localparam logic [7:0] CharComma = 8'h2C;
   localparam logic [7:0] CharPlus  = 8'h2B;
   localparam logic [7:0] CharMinus = 8'h2D;
   localparam logic [7:0] CharSpace = 8'h20;

   localparam logic [3:0] ReplyNone    = 4'd0;
   localparam logic [3:0] ReplyAckR    = 4'd1;
   localparam logic [3:0] ReplyAckI    = 4'd2;
   localparam logic [3:0] ReplyAckD    = 4'd3;
   localparam logic [3:0] ReplyAckS    = 4'd4;
   localparam logic [3:0] ReplyRefused = 4'd5;
   localparam logic [3:0] ReplyBadCmd  = 4'd6;
   localparam logic [3:0] ReplyQFull   = 4'd7;
   localparam logic [3:0] ReplyBadMsg  = 4'd8;

   localparam logic [1:0] LinkIdle   = 2'd0;
   localparam logic [1:0] LinkGame   = 2'd1;
   localparam logic [1:0] LinkCenter = 2'd2;
   localparam logic [1:0] LinkDisc   = 2'd3;

   // Parser phases.
   typedef enum logic [2:0] {
      PS_SPACE  = 3'b001,
      PS_DIGIT  = 3'b010,
      PS_DONE   = 3'b100
   } parse_phase_type;

   // Number parser result.
   typedef struct packed {
      logic                        done;
      logic signed [PulseBits-1:0] x;
      logic signed [PulseBits-1:0] y;
   } parse_result_type;

   function automatic logic is_space(input logic [7:0] b);
      is_space = (b == CharSpace) || (b >= 8'd9 && b <= 8'd13);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      is_digit = (b >= 8'h30) && (b <= 8'h39);
   endfunction
endpackage

// File: hw/rtl/dfcr_parser.sv
// Decimal parser for move payloads; takes one character per cycle while step is asserted.
module dfcr_parser
   import dfcr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  step,
   input  logic [7:0]            char_in,
   input  logic                  at_end,
   output parse_result_type      result
);
   parse_phase_type             phase_ff, phase_in;
   logic                        second_ff, second_in;
   logic                        neg_ff, neg_in;
   logic                        any_ff, any_in;
   logic [MagBits-1:0]          mag_ff, mag_in;
   logic signed [PulseBits-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [PulseBits-1:0] sat_val;
   logic [MagBits+3:0]          mag_ext;
   localparam logic [MagBits-1:0] MaxPos = MagBits'((64'd1 << (PulseBits - 1)) - 1);

   // Saturate the current magnitude into the pulse range.
   always_comb begin
      if (!any_ff) begin
         sat_val = '0;
      end else if (neg_ff) begin
         sat_val = (mag_ff > MaxPos) ? {1'b1, {(PulseBits-1){1'b0}}}
                                     : PulseBits'(-$signed({1'b0, mag_ff}));
      end else begin
         sat_val = (mag_ff > MaxPos) ? {1'b0, {(PulseBits-1){1'b1}}}
                                     : PulseBits'(mag_ff);
      end
   end

   assign mag_ext = ({4'd0, mag_ff} << 3) + ({4'd0, mag_ff} << 1)
                    + (MagBits+4)'(char_in - 8'h30);

   // Step the scan over one stored character; every step takes one character.
   always_comb begin
      phase_in  = phase_ff;
      second_in = second_ff;
      neg_in    = neg_ff;
      any_in    = any_ff;
      mag_in    = mag_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      if (start) begin
         phase_in = PS_SPACE; second_in = 1'b0; neg_in = 1'b0; any_in = 1'b0;
         mag_in = '0; x_in = '0; y_in = '0;
      end else if (step) begin
         unique case (phase_ff)
            PS_SPACE: begin
               if (!at_end && is_space(char_in)) begin
                  phase_in = PS_SPACE;
               end else if (!at_end && (char_in == CharPlus || char_in == CharMinus)) begin
                  neg_in   = (char_in == CharMinus);
                  phase_in = PS_DIGIT;
               end else if (!at_end && is_digit(char_in)) begin
                  mag_in   = MagBits'(mag_ext);
                  any_in   = 1'b1;
                  phase_in = PS_DIGIT;
               end else begin
                  // A number without digits reads as zero and ends the scan.
                  phase_in = PS_DONE;
               end
            end
            PS_DIGIT: begin
               if (!at_end && is_digit(char_in)) begin
                  if (mag_ff < (MagBits'(1) << 40)) mag_in = MagBits'(mag_ext);
                  any_in = 1'b1;
               end else if (second_ff) begin
                  y_in = sat_val; phase_in = PS_DONE;
               end else if (any_ff && !at_end && char_in == CharComma) begin
                  x_in = sat_val;
                  second_in = 1'b1; neg_in = 1'b0; any_in = 1'b0; mag_in = '0;
                  phase_in = PS_SPACE;
               end else begin
                  x_in = sat_val;
                  phase_in = PS_DONE;
               end
            end
            PS_DONE: phase_in = PS_DONE;
            default: phase_in = PS_DONE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PS_DONE;
      end else begin
         phase_ff <= phase_in;
      end
      second_ff <= second_in;
      neg_ff    <= neg_in;
      any_ff    <= any_in;
      mag_ff    <= mag_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
   end

   assign result.done = (phase_ff == PS_DONE);
   assign result.x    = x_ff;
   assign result.y    = y_ff;
endmodule

// File: hw/rtl/duplicated_frame_command_receiver.sv
// Top level of the duplicated frame command receiver.
// Payload bytes are taken one a cycle while the receiver is idle; a '#' then stalls the input
// while the frame is copied. A ';' compares and parses the frame one byte a cycle, and
// its result goes to the output register once any earlier result stalled there has left.
// Synchronous reset empties both frame copies and the move queue, link disconnected.
module duplicated_frame_command_receiver
   import dfcr_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_rx_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [3:0]                  rsp_reply_code,
   output logic                        rsp_frame_error,
   output logic [1:0]                  rsp_link_state_out,
   output logic                        rsp_move_valid,
   output logic signed [PulseBits-1:0] rsp_move_x,
   output logic signed [PulseBits-1:0] rsp_move_y
);
   typedef enum logic [7:0] {
      ST_IDLE  = 8'b00000001,
      ST_COPY  = 8'b00000010,
      ST_CMP   = 8'b00000100,
      ST_HEAD  = 8'b00001000,
      ST_PARSE = 8'b00010000,
      ST_DEQ   = 8'b00100000,
      ST_DEQW  = 8'b01000000,
      ST_OUT   = 8'b10000000
   } state_type;

   state_type                   state_ff, state_in;
   logic [7:0]                  frame_mem [FrameBytes];
   logic [7:0]                  copy_mem  [FrameBytes];
   logic [2*PulseBits-1:0]      move_mem  [QueueDepth];
   logic [FillBits-1:0]         fill_ff, copy_len_ff, idx_ff;
   logic [7:0]                  frame_rd_ff, copy_rd_ff, head_ff, code_ff;
   logic [1:0]                  link_ff;
   logic [QueueAw-1:0]          qhead_ff, qtail_ff;
   logic [QFillBits-1:0]        qfill_ff;
   logic [2*PulseBits-1:0]      move_rd_ff;
   logic                        mismatch_ff, rd_ok_ff;
   logic                        rsp_valid_ff;
   logic [3:0]                  reply_ff;
   logic                        ferr_ff, mv_ff;
   logic signed [PulseBits-1:0] mx_ff, my_ff;
   logic [3:0]                  out_reply_ff;
   logic                        out_ferr_ff, out_mv_ff;
   logic [1:0]                  out_link_ff;
   logic signed [PulseBits-1:0] out_mx_ff, out_my_ff;
   logic                        out_free;
   logic                        parse_start, parse_step, at_end;
   parse_result_type            parse_res;
   logic                        accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Move parser walks the stored frame from index 1.
   assign parse_start = (state_ff == ST_HEAD);
   assign parse_step  = (state_ff == ST_PARSE) && rd_ok_ff;
   assign at_end      = (idx_ff - FillBits'(1)) >= fill_ff;

   dfcr_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .start   (parse_start),
      .step    (parse_step),
      .char_in (frame_rd_ff),
      .at_end  (at_end),
      .result  (parse_res)
   );

   // Memories with registered reads.
   always_ff @(posedge clock) begin
      if (accept && req_rx_byte != CharHash && req_rx_byte != CharSemi
          && fill_ff < FillBits'(FrameBytes)) begin
         frame_mem[fill_ff[FrameAw-1:0]] <= req_rx_byte;
      end
      if (state_ff == ST_COPY && rd_ok_ff) begin
         copy_mem[FrameAw'(idx_ff - FillBits'(1))] <= frame_rd_ff;
      end
      frame_rd_ff <= frame_mem[idx_ff[FrameAw-1:0]];
      copy_rd_ff  <= copy_mem[idx_ff[FrameAw-1:0]];
      if (state_ff == ST_PARSE && parse_res.done && qfill_ff < QFillBits'(QueueDepth)) begin
         move_mem[qtail_ff] <= {parse_res.x, parse_res.y};
      end
      move_rd_ff <= move_mem[qhead_ff];
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         copy_len_ff  <= '0;
         link_ff      <= LinkDisc;
         qhead_ff     <= '0;
         qtail_ff     <= '0;
         qfill_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         rd_ok_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_IDLE: begin
               idx_ff      <= '0;
               rd_ok_ff    <= 1'b0;
               mismatch_ff <= accept && (req_rx_byte == CharSemi)
                              && (fill_ff != copy_len_ff);
               if (accept) begin
                  if (req_rx_byte == CharHash) begin
                     copy_len_ff <= fill_ff;
                  end else if (req_rx_byte != CharSemi && fill_ff < FillBits'(FrameBytes)) begin
                     fill_ff <= fill_ff + FillBits'(1);
                  end
               end
            end
            ST_COPY: begin
               idx_ff   <= idx_ff + FillBits'(1);
               rd_ok_ff <= 1'b1;
               if (idx_ff >= copy_len_ff) fill_ff <= '0;
            end
            ST_CMP: begin
               idx_ff   <= idx_ff + FillBits'(1);
               rd_ok_ff <= 1'b1;
               // Only bytes inside the frame take part in the comparison.
               if (rd_ok_ff && idx_ff <= fill_ff && frame_rd_ff != copy_rd_ff)
                  mismatch_ff <= 1'b1;
               if (idx_ff == FillBits'(0)) head_ff <= frame_rd_ff;
            end
            ST_HEAD: begin
               // Result is decided here for everything but moves.
               ferr_ff  <= mismatch_ff;
               mv_ff    <= 1'b0;
               mx_ff    <= '0;
               my_ff    <= '0;
               idx_ff   <= FillBits'(1);
               rd_ok_ff <= 1'b0;
               if (mismatch_ff) begin
                  link_ff  <= LinkDisc;
                  reply_ff <= ReplyNone;
               end else if (fill_ff != '0 && head_ff == CharBang) begin
                  case (fill_ff >= FillBits'(2) ? code_ff : 8'd0)
                     CharR: begin link_ff <= LinkCenter; reply_ff <= ReplyAckR; end
                     CharI: begin link_ff <= LinkIdle;   reply_ff <= ReplyAckI; end
                     CharD: begin link_ff <= LinkDisc;   reply_ff <= ReplyAckD; end
                     CharS: begin
                        if (link_ff != LinkIdle) begin
                           reply_ff <= ReplyRefused;
                        end else begin
                           link_ff  <= LinkGame;
                           reply_ff <= ReplyAckS;
                        end
                     end
                     default: reply_ff <= ReplyBadCmd;
                  endcase
               end else if (fill_ff != '0 && head_ff == CharX) begin
                  reply_ff <= ReplyNone;
               end else begin
                  link_ff  <= LinkDisc;
                  reply_ff <= ReplyBadMsg;
               end
            end
            ST_PARSE: begin
               // The read address runs one ahead of the character being parsed.
               idx_ff   <= idx_ff + FillBits'(1);
               rd_ok_ff <= 1'b1;
               if (parse_res.done) begin
                  if (qfill_ff < QFillBits'(QueueDepth)) begin
                     qtail_ff <= QueueAw'(qtail_ff + QueueAw'(1));
                     qfill_ff <= qfill_ff + QFillBits'(1);
                  end else begin
                     reply_ff <= ReplyQFull;
                  end
               end
            end
            ST_DEQ: ;
            ST_DEQW: begin
               mv_ff    <= 1'b1;
               mx_ff    <= move_rd_ff[2*PulseBits-1:PulseBits];
               my_ff    <= move_rd_ff[PulseBits-1:0];
               qhead_ff <= QueueAw'(qhead_ff + QueueAw'(1));
               qfill_ff <= qfill_ff - QFillBits'(1);
            end
            ST_OUT: begin
               // Load the output register once the previous result has left.
               if (out_free) begin
                  fill_ff      <= '0;
                  out_reply_ff <= reply_ff;
                  out_ferr_ff  <= ferr_ff;
                  out_link_ff  <= link_ff;
                  out_mv_ff    <= mv_ff;
                  out_mx_ff    <= mx_ff;
                  out_my_ff    <= my_ff;
               end
            end
            default: ;
         endcase
         if (state_ff == ST_CMP && idx_ff == FillBits'(2)) code_ff <= frame_rd_ff;
         if (state_ff == ST_OUT && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_rx_byte == CharHash) state_in = ST_COPY;
            else if (accept && req_rx_byte == CharSemi) state_in = ST_CMP;
         end
         ST_COPY: if (idx_ff >= copy_len_ff) state_in = ST_IDLE;
         ST_CMP:  if (idx_ff >= fill_ff + FillBits'(1) && idx_ff >= FillBits'(3))
                     state_in = ST_HEAD;
         ST_HEAD: begin
            if (!mismatch_ff && fill_ff != '0 && head_ff == CharX && head_ff != CharBang)
               state_in = ST_PARSE;
            else if (mismatch_ff) state_in = ST_OUT;
            else state_in = ST_DEQ;
         end
         ST_PARSE: if (parse_res.done) state_in = ST_DEQ;
         ST_DEQ:  state_in = (link_ff == LinkGame && qfill_ff != '0) ? ST_DEQW : ST_OUT;
         ST_DEQW: state_in = ST_OUT;
         ST_OUT:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_reply_code     = out_reply_ff;
   assign rsp_frame_error    = out_ferr_ff;
   assign rsp_link_state_out = out_link_ff;
   assign rsp_move_valid     = out_mv_ff;
   assign rsp_move_x         = out_mx_ff;
   assign rsp_move_y         = out_my_ff;

   // A frame error never hands out a move or a reply.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_error |-> !rsp_move_valid && rsp_reply_code == ReplyNone)
      else $error("move or reply with frame error");

   // The queue never holds more than its depth.
   assert property (@(posedge clock) disable iff (reset)
      qfill_ff <= QFillBits'(QueueDepth))
      else $error("queue overfilled");

   // A frame error always leaves the link disconnected.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_error |-> rsp_link_state_out == LinkDisc)
      else $error("frame error without disconnect");
endmodule
